@@ design/scurve_motion_profile_generator_macros.svh @@
// assertion macros for the s-curve motion profile generator
// no dependencies; compiled out when NO_ASSERTIONS is defined
`ifndef SCURVE_MOTION_PROFILE_GENERATOR_MACROS_SVH
`define SCURVE_MOTION_PROFILE_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define SCMP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("scmp assertion failed");
// antecedent implies consequent in the next cycle
`define SCMP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("scmp assertion failed");
`else
`define SCMP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons)
`define SCMP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

@@ design/scmp_pkg.sv @@
// shared types, constants and helpers for the s-curve motion profile generator
// no dependencies
`default_nettype none
package scmp_pkg;

  localparam int VALUE_WIDTH = 48;
  localparam int TICK_WIDTH  = 20;
  localparam int N_WIDTH     = 16;
  localparam int JERK_WIDTH  = 47;
  localparam int CFG_IDX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH = JERK_WIDTH;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SEGMENT_TICKS  = 1'b0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_JERK_INCREMENT = 1'b1;

  localparam logic [N_WIDTH-1:0] SEGMENT_TICKS_RESET = N_WIDTH'(6);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [2:0] {
    SEG_JERK_UP    = 3'd0,
    SEG_COAST_UP   = 3'd1,
    SEG_JERK_DOWN  = 3'd2,
    SEG_CRUISE     = 3'd3,
    SEG_BRAKE_DOWN = 3'd4,
    SEG_COAST_DOWN = 3'd5,
    SEG_BRAKE_UP   = 3'd6,
    SEG_DONE       = 3'd7
  } seg_t;

  typedef struct packed {
    logic [TICK_WIDTH-1:0]         tick;
    logic signed [VALUE_WIDTH-1:0] accel;
    logic signed [VALUE_WIDTH-1:0] vel;
    logic signed [VALUE_WIDTH-1:0] pos;
  } profile_state_t;

  typedef struct packed {
    seg_t seg;
    logic done;
  } tick_status_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // add with clamp to the signed value range
  function automatic value_t sat_add(input value_t a, input value_t b);
    logic signed [VALUE_WIDTH:0] s;
    s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
    if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
      return s[VALUE_WIDTH] ? VALUE_MIN : VALUE_MAX;
    end
    return s[VALUE_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

@@ design/scmp_tick.sv @@
// one tick of the profile: segment decode, jerk select and chained saturating adds
// depends on scmp_pkg
`default_nettype none
module scmp_tick (
  input  wire logic [scmp_pkg::N_WIDTH-1:0]    segment_ticks,
  input  wire logic [scmp_pkg::JERK_WIDTH-1:0] jerk_increment,
  input  wire logic                            restart,
  input  wire scmp_pkg::profile_state_t        state_cur,
  output scmp_pkg::profile_state_t             state_nxt,
  output scmp_pkg::tick_status_t               status
);
  import scmp_pkg::*;

  logic [TICK_WIDTH-1:0] n1, n2, n3, n6, n7, n8, n9;
  profile_state_t        base;
  seg_t                  seg;
  value_t                jerk_mag;
  value_t                jerk;
  value_t                accel_new, vel_new, pos_new;

  // unit boundaries from shifts and adds
  always_comb begin
    n1 = TICK_WIDTH'(segment_ticks);
    n2 = n1 << 1;
    n3 = n2 + n1;
    n6 = n3 << 1;
    n7 = n6 + n1;
    n8 = n1 << 3;
    n9 = n8 + n1;
  end

  assign base = restart ? '0 : state_cur;

  always_comb begin
    priority if (base.tick < n1) seg = SEG_JERK_UP;
    else if (base.tick < n2)     seg = SEG_COAST_UP;
    else if (base.tick < n3)     seg = SEG_JERK_DOWN;
    else if (base.tick < n6)     seg = SEG_CRUISE;
    else if (base.tick < n7)     seg = SEG_BRAKE_DOWN;
    else if (base.tick < n8)     seg = SEG_COAST_DOWN;
    else if (base.tick < n9)     seg = SEG_BRAKE_UP;
    else                         seg = SEG_DONE;
  end

  // the 47-bit register never exceeds the positive range, so no clamp is needed
  assign jerk_mag = value_t'({1'b0, jerk_increment});

  always_comb begin
    unique case (seg)
      SEG_JERK_UP, SEG_BRAKE_UP:      jerk = jerk_mag;
      SEG_JERK_DOWN, SEG_BRAKE_DOWN:  jerk = -jerk_mag;
      default:                        jerk = '0;
    endcase
  end

  assign accel_new = sat_add(base.accel, jerk);
  assign vel_new   = sat_add(base.vel, accel_new);
  assign pos_new   = sat_add(base.pos, vel_new);

  always_comb begin
    status.seg  = seg;
    status.done = (seg == SEG_DONE);
    if (status.done) begin
      state_nxt = base;
    end else begin
      state_nxt.tick  = base.tick + TICK_WIDTH'(1);
      state_nxt.accel = accel_new;
      state_nxt.vel   = vel_new;
      state_nxt.pos   = pos_new;
    end
  end

endmodule
`default_nettype wire

@@ design/scurve_motion_profile_generator.sv @@
// Jerk-limited point-to-point profile: every accepted transaction is one sample
// tick and yields one result transaction with position, velocity and acceleration
// after that tick, the segment it fell in and a done flag once 9N ticks have run.
// A tick is accepted every cycle while the result register is free or being
// drained; its result is registered and valid in the cycle after acceptance. The
// segment compare and the three chained 48-bit saturating adds sit ahead of that register. Write the
// configuration registers only while no tick is outstanding.
// depends on scmp_pkg, scmp_tick and scurve_motion_profile_generator_macros.svh
`default_nettype none
`include "scurve_motion_profile_generator_macros.svh"
module scurve_motion_profile_generator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [scmp_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [scmp_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_restart,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [scmp_pkg::VALUE_WIDTH-1:0]  out_position,
  output logic signed [scmp_pkg::VALUE_WIDTH-1:0]  out_velocity,
  output logic signed [scmp_pkg::VALUE_WIDTH-1:0]  out_acceleration,
  output logic [2:0]                               out_segment,
  output logic                                     out_done_res
);
  import scmp_pkg::*;

  logic [N_WIDTH-1:0]    segment_ticks_r;
  logic [JERK_WIDTH-1:0] jerk_increment_r;
  profile_state_t        state_r, state_nxt;
  tick_status_t          status;
  seg_t                  seg_r;
  logic                  done_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segment_ticks_r  <= SEGMENT_TICKS_RESET;
      jerk_increment_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEGMENT_TICKS:  segment_ticks_r  <= cfg_wdata[N_WIDTH-1:0];
        CFG_JERK_INCREMENT: jerk_increment_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  scmp_tick u_tick (
    .segment_ticks  (segment_ticks_r),
    .jerk_increment (jerk_increment_r),
    .restart        (in_restart),
    .state_cur      (state_r),
    .state_nxt      (state_nxt),
    .status         (status)
  );

  assign in_ready      = !out_valid_r || out_ready;
  assign in_fire       = in_valid && in_ready;
  assign out_valid_nxt = in_fire || (out_valid_r && !out_ready);

  // state after the tick doubles as the result payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
      seg_r       <= SEG_JERK_UP;
      done_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        state_r <= state_nxt;
        seg_r   <= status.seg;
        done_r  <= status.done;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = state_r.pos;
  assign out_velocity     = state_r.vel;
  assign out_acceleration = state_r.accel;
  assign out_segment      = seg_r;
  assign out_done_res     = done_r;

  `SCMP_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, in_fire, out_valid_r)
  `SCMP_ASSERT_NEXT(a_finished_holds, clk, rst_n, in_fire && !in_restart && status.done,
    $stable(state_r))
  `SCMP_ASSERT_NEXT(a_restart_clears_tick, clk, rst_n, in_fire && in_restart,
    state_r.tick == TICK_WIDTH'(1) || state_r.tick == '0)
  `SCMP_ASSERT_NOW(a_done_matches_segment, clk, rst_n, out_valid_r,
    done_r == (seg_r == SEG_DONE))

endmodule
`default_nettype wire

@@ dv/scurve_motion_profile_generator_tb.sv @@
// testbench for scurve_motion_profile_generator: sends sample ticks, predicts each
// result transaction in a local profile model and checks it field by field
// depends on scmp_pkg and the block under test
`timescale 1ns / 1ps
module scurve_motion_profile_generator_tb;
  import scmp_pkg::*;

  typedef struct {
    value_t pos;
    value_t vel;
    value_t acc;
    seg_t   seg;
    bit     done;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VALUE_WIDTH-1:0] out_position;
  logic signed [VALUE_WIDTH-1:0] out_velocity;
  logic signed [VALUE_WIDTH-1:0] out_acceleration;
  logic [2:0] out_segment;
  logic out_done_res;

  scurve_motion_profile_generator dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_position(out_position),
    .out_velocity(out_velocity),
    .out_acceleration(out_acceleration),
    .out_segment(out_segment),
    .out_done_res(out_done_res)
  );

  always #6 clk = ~clk;

  // profile model state and register copies
  logic [N_WIDTH-1:0]    unit_ticks = SEGMENT_TICKS_RESET;
  logic [JERK_WIDTH-1:0] jerk_step = '0;
  logic [TICK_WIDTH-1:0] move_tick = '0;
  value_t move_acc = '0;
  value_t move_vel = '0;
  value_t move_pos = '0;

  bit restart_queue[$];
  tick_result_t profile_expected[$];
  tick_result_t want;
  bit tick_taken = 1'b0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int ticks_checked = 0;
  int done_seen = 0;
  int clamped_seen = 0;
  int reg_writes = 0;

  function automatic value_t clamp_add(input value_t a, input value_t b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(VALUE_MAX)) return VALUE_MAX;
    if (s < longint'(VALUE_MIN)) return VALUE_MIN;
    return value_t'(s);
  endfunction

  function automatic seg_t segment_for(input int unsigned t, input int unsigned n);
    if (t < n) return SEG_JERK_UP;
    if (t < 2 * n) return SEG_COAST_UP;
    if (t < 3 * n) return SEG_JERK_DOWN;
    if (t < 6 * n) return SEG_CRUISE;
    if (t < 7 * n) return SEG_BRAKE_DOWN;
    if (t < 8 * n) return SEG_COAST_DOWN;
    if (t < 9 * n) return SEG_BRAKE_UP;
    return SEG_DONE;
  endfunction

  function automatic tick_result_t advance_profile(input bit restart);
    tick_result_t r;
    value_t jv;
    seg_t s;
    if (restart) begin
      move_tick = '0;
      move_acc = '0;
      move_vel = '0;
      move_pos = '0;
    end
    s = segment_for(32'(move_tick), 32'(unit_ticks));
    if (s != SEG_DONE) begin
      // a 47-bit jerk always fits the positive value range
      case (s)
        SEG_COAST_UP, SEG_CRUISE, SEG_COAST_DOWN: jv = '0;
        SEG_JERK_DOWN, SEG_BRAKE_DOWN: jv = -value_t'({1'b0, jerk_step});
        default: jv = value_t'({1'b0, jerk_step});
      endcase
      move_acc = clamp_add(move_acc, jv);
      move_vel = clamp_add(move_vel, move_acc);
      move_pos = clamp_add(move_pos, move_vel);
      move_tick = move_tick + TICK_WIDTH'(1);
    end
    r.pos = move_pos;
    r.vel = move_vel;
    r.acc = move_acc;
    r.seg = s;
    r.done = (s == SEG_DONE);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, exp_val);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || tick_taken) begin
      if (restart_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_restart <= restart_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor: predict on input transaction, check on result transaction
  always @(posedge clk) begin
    tick_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tick_taken = 1'b1;
        profile_expected.push_back(advance_profile(in_restart));
      end
      if (out_valid && out_ready) begin
        if (profile_expected.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(out_position), 64'd0);
        end else begin
          want = profile_expected.pop_front();
          ticks_checked++;
          if (want.done) done_seen++;
          if (want.pos == VALUE_MAX || want.pos == VALUE_MIN || want.vel == VALUE_MAX ||
              want.vel == VALUE_MIN || want.acc == VALUE_MAX || want.acc == VALUE_MIN)
            clamped_seen++;
          if (out_position !== want.pos)
            report_mismatch("position", 64'(out_position), 64'(want.pos));
          if (out_velocity !== want.vel)
            report_mismatch("velocity", 64'(out_velocity), 64'(want.vel));
          if (out_acceleration !== want.acc)
            report_mismatch("acceleration", 64'(out_acceleration), 64'(want.acc));
          if (out_segment !== want.seg)
            report_mismatch("segment", 64'(out_segment), 64'(want.seg));
          if (out_done_res !== want.done)
            report_mismatch("done_res", 64'(out_done_res), 64'(want.done));
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_SEGMENT_TICKS) unit_ticks = data[N_WIDTH-1:0];
    else jerk_step = data[JERK_WIDTH-1:0];
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_move(input int unsigned len, input bit fresh);
    restart_queue.push_back(fresh);
    for (int unsigned k = 1; k < len; k++) restart_queue.push_back(1'b0);
  endtask

  // wait until every tick is sent and its result is back
  // sampled at the rising edge, where the queue and in_valid are stable
  task automatic settle();
    do @(posedge clk);
    while (restart_queue.size() != 0 || in_valid || profile_expected.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  initial begin
    int unsigned budget;
    int unsigned len;
    int unsigned pick;
    logic [N_WIDTH-1:0] n_val;
    logic [CFG_DATA_WIDTH-1:0] j_val;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset values of the registers and the state
    queue_move(2, 1'b0);
    settle();
    // shortest units with the largest jerk: all segments, clamping at the positive limit, done
    write_reg(CFG_SEGMENT_TICKS, CFG_DATA_WIDTH'(1));
    write_reg(CFG_JERK_INCREMENT, {JERK_WIDTH{1'b1}});
    queue_move(11, 1'b1);
    settle();
    write_reg(CFG_SEGMENT_TICKS, CFG_DATA_WIDTH'(16'hFFFF));
    write_reg(CFG_JERK_INCREMENT, CFG_DATA_WIDTH'(1));
    queue_move(2, 1'b1);
    settle();
    // length lowered below the elapsed ticks mid-move
    write_reg(CFG_SEGMENT_TICKS, CFG_DATA_WIDTH'(2));
    write_reg(CFG_JERK_INCREMENT, CFG_DATA_WIDTH'({$urandom, $urandom} >> 30));
    queue_move(12, 1'b1);
    settle();
    write_reg(CFG_SEGMENT_TICKS, CFG_DATA_WIDTH'(1));
    queue_move(1, 1'b0);
    settle();
    // zero unit length finishes at once
    write_reg(CFG_SEGMENT_TICKS, CFG_DATA_WIDTH'(0));
    queue_move(1, 1'b1);
    settle();

    for (int p = 0; p < 8; p++) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) n_val = N_WIDTH'($urandom_range(1, 6));
      else if (pick < 17) n_val = N_WIDTH'($urandom_range(7, 30));
      else if (pick == 17) n_val = '0;
      else if (pick == 18) n_val = '1;
      else n_val = N_WIDTH'($urandom_range(0, 65535));
      pick = $urandom_range(0, 5);
      if (pick == 0) j_val = '0;
      else if (pick == 1) j_val = '1;
      else j_val = CFG_DATA_WIDTH'({$urandom, $urandom} >> $urandom_range(17, 60));
      if (p == 0) j_val = '1;
      write_reg(CFG_SEGMENT_TICKS, CFG_DATA_WIDTH'(n_val));
      write_reg(CFG_JERK_INCREMENT, j_val);
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 64; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 64; end
        default: begin send_gap_pct = 10; recv_stall_pct = 10; end
      endcase
      budget = 75;
      while (budget > 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          // noise: scattered restarts
          len = $urandom_range(1, 10);
          if (len > budget) len = budget;
          for (int unsigned k = 0; k < len; k++)
            restart_queue.push_back($urandom_range(0, 3) == 0);
        end else begin
          // full move, sometimes carried on without a restart
          len = 9 * int'(n_val) + $urandom_range(1, 4);
          if (len > budget) len = budget;
          queue_move(len, pick != 2);
        end
        budget -= len;
      end
      settle();
    end

    send_gap_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(negedge clk);
    if (profile_expected.size() != 0)
      report_mismatch("results never delivered", 64'(profile_expected.size()), 64'd0);
    $display("checked %0d ticks over %0d register writes under four pacing modes",
             ticks_checked, reg_writes);
    $display("%0d ticks past the end of a move, %0d ticks with a clamped value",
             done_seen, clamped_seen);
    if (mismatch_count == 0) begin
      $display("scurve_motion_profile_generator verification clean");
    end else begin
      $display("scurve_motion_profile_generator verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for result transactions");
    $display("scurve_motion_profile_generator verification failed");
    $finish;
  end

endmodule
